[rtl/core/profile_table_interpolator_top_macros.svh]
// Assertion macros for the profile table interpolator
`ifndef PROFILE_TABLE_INTERPOLATOR_TOP_MACROS_SVH
`define PROFILE_TABLE_INTERPOLATOR_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define PTI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pti_pkg.sv]
// Constants, types and table request struct for the profile table interpolator
`default_nettype none

package pti_pkg;

  localparam int PROFILE_TYPES = 2;
  localparam int ENERGY_ROWS   = 32;
  localparam int DIST_COLS     = 128;

  localparam int TYPE_W = (PROFILE_TYPES > 1) ? $clog2(PROFILE_TYPES) : 1;
  localparam int ROW_W  = $clog2(ENERGY_ROWS);
  localparam int HROW_W = (ROW_W > 1) ? ROW_W - 1 : 1;
  localparam int COL_W  = $clog2(DIST_COLS);
  localparam int ADDR_W = TYPE_W + HROW_W + COL_W;
  localparam int BANK_DEPTH = 2 ** ADDR_W;

  localparam logic [15:0] SNAP_LOW   = 16'd3277;
  localparam logic [15:0] SNAP_HIGH  = 16'd62260;
  localparam int          ROUND_HALF = 32768;

  typedef enum logic [1:0] {
    OP_ENTRY  = 2'd0,
    OP_HEADER = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef struct packed {
    logic [15:0] frac;
    logic [15:0] err;
  } entry_t;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic   we;
    logic   wbank;
    addr_t  waddr;
    entry_t wdata;
    addr_t  raddr_even;
    addr_t  raddr_odd;
  } tbl_req_t;

endpackage

`default_nettype wire

[rtl/core/pti_stream_if.sv]
// Request and result channel interfaces for the profile table interpolator
`default_nettype none

interface pti_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  profile_type;
  logic [11:0] entry_index;
  logic [15:0] entry_frac;
  logic [15:0] entry_err;
  logic [15:0] hdr_energy_min;
  logic [16:0] hdr_energy_recip;
  logic [15:0] hdr_dist_max;
  logic [16:0] hdr_dist_recip;
  logic [5:0]  hdr_rows;
  logic [15:0] query_dist;
  logic [15:0] query_energy;

  modport source (
    output valid, op, profile_type, entry_index, entry_frac, entry_err,
           hdr_energy_min, hdr_energy_recip, hdr_dist_max, hdr_dist_recip,
           hdr_rows, query_dist, query_energy,
    input  ready
  );

  modport sink (
    input  valid, op, profile_type, entry_index, entry_frac, entry_err,
           hdr_energy_min, hdr_energy_recip, hdr_dist_max, hdr_dist_recip,
           hdr_rows, query_dist, query_energy,
    output ready
  );
endinterface

interface pti_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_frac;
  logic [15:0] out_err;
  logic        hit;

  modport source (output valid, out_frac, out_err, hit, input ready);
  modport sink   (input valid, out_frac, out_err, hit, output ready);
endinterface

`default_nettype wire

[rtl/core/pti_table.sv]
// Profile table storage: even-row and odd-row banks with registered reads
`default_nettype none

module pti_table (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire pti_pkg::tbl_req_t req,
  output pti_pkg::entry_t        rd_even,
  output pti_pkg::entry_t        rd_odd
);
  import pti_pkg::*;

  entry_t mem_even [BANK_DEPTH];
  entry_t mem_odd  [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we && !req.wbank) begin
      mem_even[req.waddr] <= req.wdata;
    end
    if (en) begin
      rd_even <= mem_even[req.raddr_even];
    end
  end

  always_ff @(posedge clk) begin
    if (req.we && req.wbank) begin
      mem_odd[req.waddr] <= req.wdata;
    end
    if (en) begin
      rd_odd <= mem_odd[req.raddr_odd];
    end
  end

endmodule

`default_nettype wire

[rtl/core/profile_table_interpolator_top.sv]
// A query result is registered in every pipeline stage and then in the output register.
// One word per cycle unless rsp stalls; each query reads each row-parity bank once.
// Entry writes land in the table from stage 3, in order with queries.
// Header writes take effect for the next accepted word.
// Reset (rst, synchronous): headers return to unwritten, pipeline empties;
// table contents are kept and undefined until written, with no clearing pass.
`default_nettype none
`include "profile_table_interpolator_top_macros.svh"

module profile_table_interpolator_top (
  input  wire logic clk,
  input  wire logic rst,
  pti_in_if.sink    req,
  pti_out_if.source rsp
);
  import pti_pkg::*;

  // header registers
  logic [15:0] hdr_emin   [PROFILE_TYPES];
  logic [16:0] hdr_erecip [PROFILE_TYPES];
  logic [15:0] hdr_dmax   [PROFILE_TYPES];
  logic [16:0] hdr_drecip [PROFILE_TYPES];
  logic [5:0]  hdr_rows   [PROFILE_TYPES];

  // handshake
  logic r1, r2, r3, r4, r5, ro;
  logic acc;
  logic s1_v, s2_v, s3_v, s4_v, s5_v, ov;

  // accept decode
  op_t              in_op;
  logic             type_ok;
  logic [TYPE_W-1:0] tsel;
  logic [11:0]      wrow_full;
  logic             entry_ok;
  logic [5:0]       rows_clamped;

  // stage 1
  logic              s1_query, s1_miss, s1_below;
  logic [15:0]       s1_ediff, s1_dist;
  logic [16:0]       s1_erecip, s1_drecip;
  logic [5:0]        s1_rows;
  logic [TYPE_W-1:0] s1_type;
  logic [ROW_W-1:0]  s1_row;
  logic [COL_W-1:0]  s1_col;
  entry_t            s1_wdata;

  // stage 2
  logic              s2_query, s2_miss, s2_below;
  logic [32:0]       s2_cprod, s2_eprod;
  logic [5:0]        s2_rows;
  logic [TYPE_W-1:0] s2_type;
  logic [ROW_W-1:0]  s2_row;
  logic [COL_W-1:0]  s2_col;
  entry_t            s2_wdata;

  // stage 3
  logic [33:0]       csum;
  logic [17:0]       col_full;
  logic [COL_W-1:0]  qcol;
  logic [16:0]       erow;
  logic [15:0]       eres;
  logic              at_top;
  logic [ROW_W-1:0]  qrow;
  logic              hi_sel_next;
  logic [15:0]       r_next;
  logic              s3_query, s3_miss, s3_hi_sel;
  logic [15:0]       s3_r;
  logic [TYPE_W-1:0] s3_type;
  logic [ROW_W-1:0]  s3_row;
  logic [COL_W-1:0]  s3_col;
  entry_t            s3_wdata;
  logic [ROW_W:0]    row_inc;
  logic [HROW_W-1:0] half_row, half_inc;
  tbl_req_t          tbl_req;
  entry_t            rd_even, rd_odd;

  // stage 4
  logic              s4_miss, s4_lo_odd, s4_hi_sel;
  logic [15:0]       s4_r;
  entry_t            lo_ent, hi_ent, base_next;
  logic signed [16:0] dfrac, derr;
  logic signed [33:0] pf_next, pe_next;

  // stage 5
  logic               s5_miss;
  entry_t             s5_base;
  logic signed [33:0] s5_pf, s5_pe;
  logic signed [34:0] sum_f, sum_e;

  // output register
  logic [15:0] o_frac, o_err;
  logic        o_hit;

  assign ro = !ov || rsp.ready;
  assign r5 = !s5_v || ro;
  assign r4 = !s4_v || r5;
  assign r3 = !s3_v || r4;
  assign r2 = !s2_v || r3;
  assign r1 = !s1_v || r2;

  assign req.ready = r1;
  assign acc       = req.valid && r1;

  always_comb begin
    in_op        = op_t'(req.op);
    type_ok      = {1'b0, req.profile_type} < 5'(PROFILE_TYPES);
    tsel         = req.profile_type[TYPE_W-1:0];
    wrow_full    = 12'(req.entry_index / DIST_COLS);
    entry_ok     = type_ok && (wrow_full < 12'(ENERGY_ROWS));
    rows_clamped = (req.hdr_rows > 6'(ENERGY_ROWS)) ? 6'(ENERGY_ROWS) : req.hdr_rows;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PROFILE_TYPES; i++) begin
        hdr_emin[i]   <= 16'd0;
        hdr_erecip[i] <= 17'd1;
        hdr_dmax[i]   <= 16'd0;
        hdr_drecip[i] <= 17'd1;
        hdr_rows[i]   <= 6'd0;
      end
    end else if (acc && in_op == OP_HEADER && type_ok) begin
      hdr_emin[tsel]   <= req.hdr_energy_min;
      hdr_erecip[tsel] <= req.hdr_energy_recip;
      hdr_dmax[tsel]   <= req.hdr_dist_max;
      hdr_drecip[tsel] <= req.hdr_dist_recip;
      hdr_rows[tsel]   <= rows_clamped;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      ov   <= 1'b0;
    end else begin
      if (r1) begin
        case (in_op)
          OP_ENTRY: s1_v <= acc && entry_ok;
          OP_QUERY: s1_v <= acc;
          default:  s1_v <= 1'b0;
        endcase
      end
      if (r2) s2_v <= s1_v;
      if (r3) s3_v <= s2_v;
      if (r4) s4_v <= s3_v && s3_query;
      if (r5) s5_v <= s4_v;
      if (ro) ov   <= s5_v;
    end
  end

  // stage 1: header snapshot and compares
  always_ff @(posedge clk) begin
    if (r1) begin
      s1_query  <= in_op == OP_QUERY;
      s1_miss   <= !type_ok || hdr_rows[tsel] == 6'd0 || req.query_dist >= hdr_dmax[tsel];
      s1_below  <= req.query_energy < hdr_emin[tsel];
      s1_ediff  <= req.query_energy - hdr_emin[tsel];
      s1_erecip <= hdr_erecip[tsel];
      s1_dist   <= req.query_dist;
      s1_drecip <= hdr_drecip[tsel];
      s1_rows   <= hdr_rows[tsel];
      s1_type   <= tsel;
      s1_row    <= ROW_W'(wrow_full);
      s1_col    <= COL_W'(req.entry_index % DIST_COLS);
      s1_wdata  <= '{frac: req.entry_frac, err: req.entry_err};
    end
  end

  // stage 2: scale products
  always_ff @(posedge clk) begin
    if (r2) begin
      s2_query <= s1_query;
      s2_miss  <= s1_miss;
      s2_below <= s1_below;
      s2_cprod <= s1_dist * s1_drecip;
      s2_eprod <= s1_ediff * s1_erecip;
      s2_rows  <= s1_rows;
      s2_type  <= s1_type;
      s2_row   <= s1_row;
      s2_col   <= s1_col;
      s2_wdata <= s1_wdata;
    end
  end

  // stage 3: column, row and blend selection
  always_comb begin
    csum     = {1'b0, s2_cprod} + 34'(ROUND_HALF);
    col_full = csum[33:16];
    qcol     = (col_full > 18'(DIST_COLS - 1)) ? COL_W'(DIST_COLS - 1) : col_full[COL_W-1:0];
    erow     = s2_eprod[32:16];
    eres     = s2_eprod[15:0];
    at_top   = ({1'b0, erow} + 18'd1) >= {12'd0, s2_rows};
    qrow        = ROW_W'(erow);
    hi_sel_next = 1'b0;
    r_next      = 16'd0;
    if (s2_below) begin
      qrow = '0;
    end else if (at_top) begin
      qrow = ROW_W'(s2_rows - 6'd1);
    end else if (eres < SNAP_LOW) begin
      qrow = ROW_W'(erow);
    end else if (eres >= SNAP_HIGH) begin
      hi_sel_next = 1'b1;
    end else begin
      r_next = eres;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      s3_query  <= s2_query;
      s3_miss   <= s2_miss;
      s3_hi_sel <= hi_sel_next;
      s3_r      <= r_next;
      s3_type   <= s2_type;
      s3_row    <= s2_query ? qrow : s2_row;
      s3_col    <= s2_query ? qcol : s2_col;
      s3_wdata  <= s2_wdata;
    end
  end

  always_comb begin
    row_inc  = {1'b0, s3_row} + (ROW_W + 1)'(1);
    half_row = HROW_W'(s3_row >> 1);
    half_inc = HROW_W'(row_inc >> 1);
    tbl_req.we         = r4 && s3_v && !s3_query;
    tbl_req.wbank      = s3_row[0];
    tbl_req.waddr      = {s3_type, half_row, s3_col};
    tbl_req.wdata      = s3_wdata;
    tbl_req.raddr_odd  = {s3_type, half_row, s3_col};
    tbl_req.raddr_even = {s3_type, (s3_row[0] ? half_inc : half_row), s3_col};
  end

  pti_table u_table (
    .clk     (clk),
    .en      (r4),
    .req     (tbl_req),
    .rd_even (rd_even),
    .rd_odd  (rd_odd)
  );

  // stage 4: table words arrive, weight the row difference
  always_ff @(posedge clk) begin
    if (r4) begin
      s4_miss   <= s3_miss;
      s4_lo_odd <= s3_row[0];
      s4_hi_sel <= s3_hi_sel;
      s4_r      <= s3_r;
    end
  end

  always_comb begin
    lo_ent    = s4_lo_odd ? rd_odd : rd_even;
    hi_ent    = s4_lo_odd ? rd_even : rd_odd;
    base_next = s4_hi_sel ? hi_ent : lo_ent;
    dfrac     = $signed({1'b0, hi_ent.frac}) - $signed({1'b0, lo_ent.frac});
    derr      = $signed({1'b0, hi_ent.err}) - $signed({1'b0, lo_ent.err});
    pf_next   = (s4_r == 16'd0) ? 34'sd0 : $signed({1'b0, s4_r}) * dfrac;
    pe_next   = (s4_r == 16'd0) ? 34'sd0 : $signed({1'b0, s4_r}) * derr;
  end

  always_ff @(posedge clk) begin
    if (r5) begin
      s5_miss <= s4_miss;
      s5_base <= base_next;
      s5_pf   <= pf_next;
      s5_pe   <= pe_next;
    end
  end

  // stage 5: round and add to the base row (the lower row, or the upper row when snapped up)
  always_comb begin
    sum_f = 35'(s5_pf) + 35'sd32768;
    sum_e = 35'(s5_pe) + 35'sd32768;
  end

  always_ff @(posedge clk) begin
    if (ro) begin
      o_frac <= s5_miss ? 16'd0 : s5_base.frac + sum_f[31:16];
      o_err  <= s5_miss ? 16'd0 : s5_base.err + sum_e[31:16];
      o_hit  <= !s5_miss;
    end
  end

  assign rsp.valid    = ov;
  assign rsp.out_frac = o_frac;
  assign rsp.out_err  = o_err;
  assign rsp.hit      = o_hit;

  `PTI_ASSERT_NEXT(a_query_enters, req.valid && req.ready && req.op == OP_QUERY, s1_v && s1_query, "accepted query did not enter the pipeline")
  `PTI_ASSERT_NOW(a_miss_zero, rsp.valid && !rsp.hit, rsp.out_frac == 16'd0 && rsp.out_err == 16'd0, "miss result carries nonzero value")
  `PTI_ASSERT_NEXT(a_s5_hold, s5_v && !r5 && !s5_miss, s5_v && $stable(s5_base) && $stable(s5_pf), "stalled blend stage lost its word")
  `PTI_ASSERT_NOW(a_rows_clamped, 1'b1, hdr_rows[0] <= 6'(ENERGY_ROWS), "header row count above table rows")

endmodule

`default_nettype wire

[tb/sv/profile_table_interpolator_top_tb.sv]
// Testbench for the profile table interpolator: directed and random table, header and query words
`timescale 1ns / 100ps

module profile_table_interpolator_top_tb;
  import pti_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  ptype;
    logic [11:0] index;
    logic [15:0] frac;
    logic [15:0] err;
    logic [15:0] e_min;
    logic [16:0] e_recip;
    logic [15:0] d_max;
    logic [16:0] d_recip;
    logic [5:0]  rows;
    logic [15:0] qdist;
    logic [15:0] energy;
  } req_word_t;

  typedef struct {
    logic [15:0] frac;
    logic [15:0] err;
    logic        hit;
  } lookup_result_t;

  typedef struct {
    bit          hit;
    int          ptype;
    int          col;
    int          row_lo;
    int          row_hi;
    bit          mix;
    logic [15:0] weight;
  } lookup_loc_t;

  logic clk = 1'b0;
  logic rst;

  pti_in_if  req_if ();
  pti_out_if rsp_if ();

  profile_table_interpolator_top dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  logic [15:0] tbl_frac_m  [PROFILE_TYPES][ENERGY_ROWS][DIST_COLS];
  logic [15:0] tbl_err_m   [PROFILE_TYPES][ENERGY_ROWS][DIST_COLS];
  bit          tbl_written [PROFILE_TYPES][ENERGY_ROWS][DIST_COLS];
  logic [15:0] hdr_emin    [PROFILE_TYPES];
  logic [16:0] hdr_erecip  [PROFILE_TYPES];
  logic [15:0] hdr_dmax    [PROFILE_TYPES];
  logic [16:0] hdr_drecip  [PROFILE_TYPES];
  logic [5:0]  hdr_rows    [PROFILE_TYPES];

  lookup_result_t expected_results[$];
  int errors = 0;
  int words_sent = 0;
  bit pacing = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_word_t random_word(logic [1:0] op, logic [3:0] ptype);
    req_word_t w;
    w.op      = op;
    w.ptype   = ptype;
    w.index   = 12'($urandom);
    w.frac    = pick16();
    w.err     = pick16();
    w.e_min   = pick16();
    w.e_recip = 17'($urandom);
    w.d_max   = pick16();
    w.d_recip = 17'($urandom);
    w.rows    = 6'($urandom);
    w.qdist   = pick16();
    w.energy  = pick16();
    return w;
  endfunction

  function automatic req_word_t header_word(int t, int emin, int erecip, int dmax, int drecip,
                                            int rows);
    req_word_t w;
    w         = random_word(OP_HEADER, 4'(t));
    w.e_min   = 16'(emin);
    w.e_recip = 17'(erecip);
    w.d_max   = 16'(dmax);
    w.d_recip = 17'(drecip);
    w.rows    = 6'(rows);
    return w;
  endfunction

  function automatic req_word_t query_word(int t, int qdist, int energy);
    req_word_t w;
    w        = random_word(OP_QUERY, 4'(t));
    w.qdist  = 16'(qdist);
    w.energy = 16'(energy);
    return w;
  endfunction

  function automatic lookup_loc_t locate(req_word_t w);
    lookup_loc_t loc;
    logic [63:0] prod;
    logic [63:0] row;
    int t;
    loc = '{default: 0};
    t = w.ptype;
    loc.ptype = t;
    if (t >= PROFILE_TYPES) return loc;
    if (hdr_rows[t] == 0 || w.qdist >= hdr_dmax[t]) return loc;
    loc.hit = 1'b1;
    prod = (64'(w.qdist) * 64'(hdr_drecip[t]) + 64'(ROUND_HALF)) >> 16;
    loc.col = (prod > DIST_COLS - 1) ? DIST_COLS - 1 : int'(prod);
    if (w.energy < hdr_emin[t]) return loc;
    prod = 64'(w.energy - hdr_emin[t]) * 64'(hdr_erecip[t]);
    row = prod >> 16;
    loc.weight = prod[15:0];
    if (row + 1 >= 64'(hdr_rows[t])) begin
      loc.row_lo = hdr_rows[t] - 1;
      loc.row_hi = loc.row_lo;
    end else if (prod[15:0] < SNAP_LOW) begin
      loc.row_lo = int'(row);
      loc.row_hi = loc.row_lo;
    end else if (prod[15:0] >= SNAP_HIGH) begin
      loc.row_lo = int'(row) + 1;
      loc.row_hi = loc.row_lo;
    end else begin
      loc.row_lo = int'(row);
      loc.row_hi = loc.row_lo + 1;
      loc.mix = 1'b1;
    end
    return loc;
  endfunction

  function automatic logic [15:0] blend16(logic [15:0] wt, logic [15:0] lo, logic [15:0] hi);
    logic [63:0] acc;
    acc = (64'(wt) * 64'(hi) + (64'd65536 - 64'(wt)) * 64'(lo) + 64'(ROUND_HALF)) >> 16;
    return acc[15:0];
  endfunction

  function automatic void apply_word(req_word_t w);
    lookup_loc_t loc;
    lookup_result_t res;
    int t;
    int row;
    int col;
    t = w.ptype;
    row = w.index / DIST_COLS;
    col = w.index % DIST_COLS;
    case (w.op)
      OP_ENTRY: begin
        if (t < PROFILE_TYPES && row < ENERGY_ROWS) begin
          tbl_frac_m[t][row][col]  = w.frac;
          tbl_err_m[t][row][col]   = w.err;
          tbl_written[t][row][col] = 1'b1;
        end
      end
      OP_HEADER: begin
        if (t < PROFILE_TYPES) begin
          hdr_emin[t]   = w.e_min;
          hdr_erecip[t] = w.e_recip;
          hdr_dmax[t]   = w.d_max;
          hdr_drecip[t] = w.d_recip;
          hdr_rows[t]   = (w.rows > ENERGY_ROWS) ? 6'(ENERGY_ROWS) : w.rows;
        end
      end
      OP_QUERY: begin
        loc = locate(w);
        res = '{frac: 16'h0000, err: 16'h0000, hit: 1'b0};
        if (loc.hit) begin
          res.hit = 1'b1;
          if (loc.mix) begin
            res.frac = blend16(loc.weight, tbl_frac_m[t][loc.row_lo][loc.col],
                               tbl_frac_m[t][loc.row_hi][loc.col]);
            res.err  = blend16(loc.weight, tbl_err_m[t][loc.row_lo][loc.col],
                               tbl_err_m[t][loc.row_hi][loc.col]);
          end else begin
            res.frac = tbl_frac_m[t][loc.row_lo][loc.col];
            res.err  = tbl_err_m[t][loc.row_lo][loc.col];
          end
        end
        expected_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  task automatic drive_fields(req_word_t w);
    req_if.op               <= w.op;
    req_if.profile_type     <= w.ptype;
    req_if.entry_index      <= w.index;
    req_if.entry_frac       <= w.frac;
    req_if.entry_err        <= w.err;
    req_if.hdr_energy_min   <= w.e_min;
    req_if.hdr_energy_recip <= w.e_recip;
    req_if.hdr_dist_max     <= w.d_max;
    req_if.hdr_dist_recip   <= w.d_recip;
    req_if.hdr_rows         <= w.rows;
    req_if.query_dist       <= w.qdist;
    req_if.query_energy     <= w.energy;
  endtask

  task automatic send_word(req_word_t w);
    int gap;
    gap = pacing ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    drive_fields(w);
    req_if.valid <= 1'b1;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    apply_word(w);
    words_sent++;
  endtask

  // fill every unwritten entry in the query's column near the rows it touches before it is sent
  task automatic send_query(req_word_t w);
    lookup_loc_t loc;
    req_word_t fill;
    int lo;
    int hi;
    int row;
    loc = locate(w);
    if (loc.hit) begin
      lo = (loc.row_lo > 0) ? loc.row_lo - 1 : 0;
      hi = (loc.row_hi < ENERGY_ROWS - 1) ? loc.row_hi + 1 : ENERGY_ROWS - 1;
      for (row = lo; row <= hi; row++) begin
        if (!tbl_written[loc.ptype][row][loc.col]) begin
          fill = random_word(OP_ENTRY, 4'(loc.ptype));
          fill.index = 12'(row * DIST_COLS + loc.col);
          send_word(fill);
        end
      end
    end
    send_word(w);
  endtask

  function automatic req_word_t random_header(int t);
    req_word_t w;
    w = random_word(OP_HEADER, 4'(t));
    if ($urandom_range(0, 5) != 0) begin
      w.e_min   = ($urandom_range(0, 3) == 0) ? pick16() : 16'($urandom_range(0, 4096));
      w.e_recip = 17'(65536 / $urandom_range(1, 512));
      w.d_max   = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(256, 65535));
      w.d_recip = 17'(65536 / $urandom_range(16, 1024));
      w.rows    = 6'($urandom_range(1, 32));
    end
    return w;
  endfunction

  function automatic req_word_t random_query(int t);
    req_word_t w;
    int unsigned step;
    int unsigned reach;
    int unsigned base;
    w = random_word(OP_QUERY, 4'(t));
    step = (hdr_erecip[t] == 0) ? 1 : 65536 / hdr_erecip[t];
    if (step == 0) step = 1;
    reach = (hdr_rows[t] + 1) * step;
    case ($urandom_range(0, 9))
      0: ;
      1: w.energy = 16'($urandom_range(0, hdr_emin[t]));
      default: begin
        base = hdr_emin[t] + $urandom_range(0, reach);
        w.energy = (base > 65535) ? 16'hFFFF : 16'(base);
      end
    endcase
    case ($urandom_range(0, 9))
      0: ;
      1: w.qdist = hdr_dmax[t];
      default: if (hdr_dmax[t] != 0) w.qdist = 16'($urandom_range(0, hdr_dmax[t] - 1));
    endcase
    return w;
  endfunction

  task automatic test_unwritten_headers();
    send_query(query_word(0, 0, 0));
    send_query(query_word(1, 16'hFFFF, 16'hFFFF));
    send_query(query_word(15, 0, 0));
    send_word(random_word(OP_UNUSED, 4'd0));
  endtask

  task automatic test_row_selection();
    int emin;
    emin = 160;
    send_word(header_word(0, emin, 1024, 16'h8000, 256, 63));
    send_query(query_word(0, 0, 0));
    send_query(query_word(0, 0, 16'hFFFF));
    send_query(query_word(0, 0, emin + 64 * 5 + 3));
    send_query(query_word(0, 0, emin + 64 * 5 + 61));
    send_query(query_word(0, 0, emin + 64 * 5 + 32));
    send_query(query_word(0, 0, emin + 64 * 30 + 40));
    send_query(query_word(0, 0, emin + 64 * 31));
    send_query(query_word(0, 16'h7FFF, 0));
    send_query(query_word(0, 16'h8000, emin));
  endtask

  task automatic test_ignored_writes_and_zero_recip();
    req_word_t w;
    w = random_word(OP_ENTRY, 4'hF);
    w.index = 12'hFFF;
    send_word(w);
    send_word(header_word(9, 0, 1, 16'hFFFF, 1, 5));
    send_word(header_word(1, 0, 0, 16'hFFFF, 0, 1));
    send_query(query_word(1, 16'hFFFE, 16'hFFFF));
    send_word(header_word(1, 16'hFFFF, 17'h10000, 16'hFFFF, 17'h10000, 32));
    send_query(query_word(1, 16'h0001, 16'hFFFF));
  endtask

  task automatic run_random_mix(int n_words, bit paced);
    req_word_t w;
    int stop_at;
    int sel;
    int t;
    pacing = paced;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      sel = $urandom_range(0, 99);
      t = $urandom_range(0, PROFILE_TYPES - 1);
      if (sel < 8) begin
        send_word(random_header(t));
      end else if (sel < 80) begin
        send_query(random_query(t));
      end else if (sel < 92) begin
        send_word(random_word(OP_ENTRY, 4'(t)));
      end else begin
        w = random_word(2'($urandom_range(0, 3)), 4'($urandom));
        if (w.op == OP_QUERY) send_query(w);
        else send_word(w);
      end
    end
  endtask

  initial begin : result_checker
    lookup_result_t exp_res;
    int stall;
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = pacing ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
      if (expected_results.size() == 0) begin
        $error("result word with no query waiting: out_frac %0d out_err %0d hit %0d",
               rsp_if.out_frac, rsp_if.out_err, rsp_if.hit);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        if (rsp_if.out_frac !== exp_res.frac) begin
          $error("out_frac: expected %0d, actual %0d", exp_res.frac, rsp_if.out_frac);
          errors++;
        end
        if (rsp_if.out_err !== exp_res.err) begin
          $error("out_err: expected %0d, actual %0d", exp_res.err, rsp_if.out_err);
          errors++;
        end
        if (rsp_if.hit !== exp_res.hit) begin
          $error("hit: expected %0d, actual %0d", exp_res.hit, rsp_if.hit);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    for (int t = 0; t < PROFILE_TYPES; t++) begin
      hdr_emin[t]   = '0;
      hdr_erecip[t] = 17'd1;
      hdr_dmax[t]   = '0;
      hdr_drecip[t] = 17'd1;
      hdr_rows[t]   = '0;
    end
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    drive_fields(random_word(OP_QUERY, 4'd0));
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_unwritten_headers();
    test_row_selection();
    test_ignored_writes_and_zero_recip();
    run_random_mix(900, 1'b1);
    run_random_mix(300, 1'b0);
    run_random_mix(500, 1'b1);

    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/pti_pkg.sv
rtl/core/pti_stream_if.sv
rtl/core/pti_table.sv
rtl/core/profile_table_interpolator_top.sv
tb/sv/profile_table_interpolator_top_tb.sv
